// ===== src/bounded_stack_with_delete_core_assert.svh =====
// Assertion macros for the stack core.
// Each macro expects clk and rst_n in scope.
`ifndef BOUNDED_STACK_WITH_DELETE_CORE_ASSERT_SVH
`define BOUNDED_STACK_WITH_DELETE_CORE_ASSERT_SVH

// Check a consequence in the same cycle as its trigger
`define BSWD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger
`define BSWD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bswd_pkg.sv =====
package bswd_pkg;

  localparam int DEPTH  = 32;
  localparam int WORD_W = 32;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_PUSH = 2'd0,
    ACT_POP  = 2'd1,
    ACT_PEEK = 2'd2,
    ACT_ELIM = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDATA,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

  // One finished result, before the empty and full flags are derived
  typedef struct packed {
    status_t           status;
    logic [WORD_W-1:0] data;
    logic              found;
    logic [CNT_W-1:0]  count;
  } res_t;

endpackage

// ===== src/bswd_ram.sv =====
module bswd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic                                 rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/bswd_seq.sv =====
module bswd_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [1:0]                    in_action,
  input  logic [bswd_pkg::WORD_W-1:0]   in_value,
  output logic                          idle,
  output logic                          done,
  input  logic                          ack,
  output bswd_pkg::res_t                res
);

  import bswd_pkg::*;

  state_t            state_r,  state_nxt;
  logic [CNT_W-1:0]  count_r,  count_nxt;
  logic [ADDR_W-1:0] pos_r,    pos_nxt;
  act_t              action_r, action_nxt;
  logic [WORD_W-1:0] value_r,  value_nxt;
  logic [WORD_W-1:0] data_r,   data_nxt;
  status_t           status_r, status_nxt;
  logic              found_r,  found_nxt;

  logic              ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic [WORD_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [WORD_W-1:0] ram_rd_data;

  logic              is_full;
  logic              is_empty;
  logic [ADDR_W-1:0] top_addr;
  logic [ADDR_W-1:0] pos_inc;
  logic [CNT_W-1:0]  pos_cnt_inc;
  logic              pos_at_top;
  logic              pos_below_top;
  logic              word_match;

  // Shared pointer and compare unit
  assign is_full       = (count_r == CNT_W'(DEPTH));
  assign is_empty      = (count_r == '0);
  assign top_addr      = ADDR_W'(count_r - 1'b1);
  assign pos_inc       = pos_r + 1'b1;
  assign pos_cnt_inc   = CNT_W'(pos_r) + 1'b1;
  assign pos_at_top    = (pos_cnt_inc == count_r);
  assign pos_below_top = ((pos_cnt_inc + 1'b1) == count_r);
  assign word_match    = (ram_rd_data == value_r);

  bswd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Next state and register values
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    action_nxt = action_r;
    value_nxt  = value_r;
    data_nxt   = data_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          action_nxt = act_t'(in_action);
          value_nxt  = in_value;
          data_nxt   = '0;
          found_nxt  = 1'b0;
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
          case (act_t'(in_action))
            ACT_PUSH: begin
              if (is_full) begin
                status_nxt = ST_FULL;
              end else begin
                count_nxt = count_r + 1'b1;
              end
            end
            ACT_POP, ACT_PEEK: begin
              if (is_empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_RDATA;
              end
            end
            ACT_ELIM: begin
              if (is_empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                pos_nxt   = top_addr;
                state_nxt = S_SCAN_RD;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_RDATA: begin
        data_nxt = ram_rd_data;
        if (action_r == ACT_POP) begin
          count_nxt = count_r - 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (word_match) begin
          found_nxt = 1'b1;
          if (pos_at_top) begin
            count_nxt = count_r - 1'b1;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SHIFT_RD;
          end
        end else if (pos_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          pos_nxt   = pos_r - 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        state_nxt = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        pos_nxt = pos_inc;
        if (pos_below_top) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SHIFT_RD;
        end
      end
      S_DONE: begin
        if (ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Memory controls and handshake
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = count_r[ADDR_W-1:0];
    ram_wr_data = in_value;
    ram_rd_en   = 1'b0;
    ram_rd_addr = top_addr;
    case (state_r)
      S_IDLE: begin
        ram_wr_en = in_valid && (act_t'(in_action) == ACT_PUSH) && !is_full;
        ram_rd_en = in_valid;
      end
      S_SCAN_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = pos_r;
      end
      S_SHIFT_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = pos_inc;
      end
      S_SHIFT_WR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = pos_r;
        ram_wr_data = ram_rd_data;
      end
      default: begin
        ram_wr_en = 1'b0;
      end
    endcase
  end

  assign idle       = (state_r == S_IDLE);
  assign done       = (state_r == S_DONE);
  assign res.status = status_r;
  assign res.data   = data_r;
  assign res.found  = found_r;
  assign res.count  = count_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    action_r <= action_nxt;
    value_r  <= value_nxt;
    data_r   <= data_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
  end

endmodule

// ===== src/bounded_stack_with_delete_core.sv =====
// From the accept edge to the result on the outputs: push and refused operations
// go straight to done, pop and peek first read the top word, and eliminate takes
// a read and a compare state per scanned word and a read and a write state per
// moved word, as the memory read is registered. A new item is taken in the cycle
// after the previous result enters the output register, so items do not overlap.
// Reset clears the fill count and output valid flag; stack words stay uncleared.
module bounded_stack_with_delete_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_action,
  input  logic signed [bswd_pkg::WORD_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_status,
  output logic signed [bswd_pkg::WORD_W-1:0]  out_data_out,
  output logic                                out_found,
  output logic [bswd_pkg::CNT_W-1:0]          out_count,
  output logic                                out_is_empty,
  output logic                                out_is_full
);

  import bswd_pkg::*;

`include "bounded_stack_with_delete_core_assert.svh"

  logic seq_idle;
  logic seq_done;
  logic load;
  res_t seq_res;
  logic out_valid_r, out_valid_nxt;
  res_t res_r;

  bswd_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_value  (in_value),
    .idle      (seq_idle),
    .done      (seq_done),
    .ack       (load),
    .res       (seq_res)
  );

  // Take the result when the output slot is free or being drained
  assign load     = seq_done && (!out_valid_r || out_ready);
  assign in_ready = seq_idle;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= seq_res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = res_r.status;
  assign out_data_out = res_r.data;
  assign out_found    = res_r.found;
  assign out_count    = res_r.count;
  assign out_is_empty = (res_r.count == '0);
  assign out_is_full  = (res_r.count == CNT_W'(DEPTH));

  `BSWD_ASSERT_NOW(a_count_bound, out_valid, out_count <= CNT_W'(DEPTH), "count above depth")
  `BSWD_ASSERT_NOW(a_refused_clean, out_valid && (out_status != ST_OK), (out_data_out == '0) && !out_found, "refused result carries data")
  `BSWD_ASSERT_NOW(a_found_elim, out_valid && out_found, (out_status == ST_OK) && !out_is_full, "found without room freed")
  `BSWD_ASSERT_NEXT(a_busy_after, in_valid && in_ready, !in_ready, "ready held through a transfer")

endmodule
